@@ hw/rtl/hblm_pkg.sv @@
// shared types and constants of the heartbeat liveness monitor
package hblm_pkg;

  // liveness level of one client, signed
  typedef logic signed [2:0] level_t;

  localparam level_t LVL_ALIVE = 3'sd1;
  localparam level_t LVL_WAIT  = 3'sd0;
  localparam level_t LVL_MISS4 = -3'sd3;
  localparam level_t LVL_AWAY  = -3'sd4;

  localparam logic [7:0]  PONG_BYTE      = 8'hAA;
  localparam logic [15:0] INTERVAL_RESET = 16'd200;
  localparam logic [4:0]  COUNT_RESET    = 5'd16;
  localparam int          PEER_LIMIT     = 16;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_MSG  = 1'b1
  } opcode_t;

  typedef enum logic {
    REG_PING_INTERVAL = 1'b0,
    REG_CLIENT_COUNT  = 1'b1
  } reg_idx_t;

endpackage

@@ hw/rtl/heartbeat_liveness_monitor.sv @@
// heartbeat liveness monitor: tracks peer liveness, issues ping rounds and link events
// Input stream s_*: one request per item. s_tuser[0] is the opcode (0 tick, 1 message);
// s_tdata carries client_index and payload_byte. Output stream m_*: one result per
// request to or event of a peer; m_tlast marks the final result of an input item.
// The APB port holds ping_interval (address 0) and client_count (address 4).
// A tick that does not end an interval only advances the interval counter and gives no result.
// A tick that ends an interval starts a ping round, if any client is active, that walks
// the level ram one client per cycle while the output register is free: each client's
// level is read through the registered ram read, then its result is loaded into m_*.
// A pong does one ram read, then the update and at most one result.
// The input is taken again as soon as a round or pong is done, even while the last
// result still waits in the output register.
// When the receiver stalls, the round pauses with the output register full and
// resumes when it is taken; nothing is dropped.
// Reset sets the interval counter to zero, both registers to their defaults and all
// clients to away at once through per-entry written bits; there is no clearing pass.
module heartbeat_liveness_monitor #(
  parameter int MAX_CLIENTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // apb configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [3:0] client_index, [11:4] payload_byte, [15:12] zero
  input  logic [0:0]  s_tuser,   // [0] opcode
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [3:0] peer_index, [7:4] zero
  output logic [2:0]  m_tuser,   // [0] send_ping, [1] link_down, [2] link_up
  output logic        m_tlast
);
  import hblm_pkg::*;

  localparam int AW = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
  localparam int ACTIVE_LIMIT = (MAX_CLIENTS < PEER_LIMIT) ? MAX_CLIENTS : PEER_LIMIT;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_PONG
  } state_t;

  state_t      state;
  logic [15:0] ping_interval;
  logic [4:0]  client_count;
  logic [15:0] tick_count;
  logic [3:0]  peer;

  logic [4:0]  n_active;
  logic        accept;
  logic        out_free;
  logic        out_load;
  logic        cfg_write;
  logic [15:0] tick_next;
  logic        round_due;
  logic        pong_ok;
  logic [3:0]  msg_client;
  logic        round_last;
  logic        round_down;
  level_t      round_level;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  level_t        rd_level;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  level_t        wr_level;

  hblm_level_ram #(
    .DEPTH (MAX_CLIENTS)
  ) u_level_ram (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_level (rd_level),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_level (wr_level)
  );

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_comb begin
    unique case (reg_idx_t'(paddr[2]))
      REG_PING_INTERVAL: prdata = {16'd0, ping_interval};
      REG_CLIENT_COUNT:  prdata = {27'd0, client_count};
      default:           prdata = '0;
    endcase
  end

  always_comb begin
    n_active   = (client_count > 5'(ACTIVE_LIMIT)) ? 5'(ACTIVE_LIMIT) : client_count;
    s_tready   = (state == ST_IDLE);
    accept     = s_tvalid & s_tready;
    out_free   = !m_tvalid || m_tready;
    out_load   = out_free &&
                 ((state == ST_ROUND) || ((state == ST_PONG) && (rd_level < LVL_WAIT)));
    tick_next  = tick_count + 16'd1;
    round_due  = (tick_next >= ping_interval);
    msg_client = s_tdata[3:0];
    pong_ok    = ({1'b0, msg_client} < n_active) && (s_tdata[11:4] == PONG_BYTE);
    round_last = (({1'b0, peer} + 5'd1) == n_active);

    // level update of a ping round
    round_down  = (rd_level == LVL_MISS4);
    if (round_down) begin
      round_level = LVL_AWAY;
    end else if (rd_level > LVL_MISS4) begin
      round_level = rd_level - 3'sd1;
    end else begin
      round_level = rd_level;
    end

    rd_en    = 1'b0;
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_addr  = AW'(peer);
    wr_level = round_level;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (opcode_t'(s_tuser[0]) == OP_TICK) begin
            rd_en = round_due && (n_active != 5'd0);
          end else begin
            rd_en   = pong_ok;
            rd_addr = AW'(msg_client);
          end
        end
      end
      ST_ROUND: begin
        if (out_free) begin
          wr_en   = 1'b1;
          rd_en   = !round_last;
          rd_addr = AW'(peer + 4'd1);
        end
      end
      ST_PONG: begin
        wr_level = LVL_ALIVE;
        if (rd_level < LVL_WAIT) begin
          wr_en = out_free;
        end else if (rd_level == LVL_WAIT) begin
          wr_en = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      ping_interval <= INTERVAL_RESET;
      client_count  <= COUNT_RESET;
      tick_count    <= '0;
      peer          <= '0;
      m_tvalid      <= 1'b0;
      m_tdata       <= '0;
      m_tuser       <= '0;
      m_tlast       <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (reg_idx_t'(paddr[2]))
          REG_PING_INTERVAL: ping_interval <= pwdata[15:0];
          REG_CLIENT_COUNT:  client_count  <= pwdata[4:0];
          default: ;
        endcase
      end

      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (opcode_t'(s_tuser[0]) == OP_TICK) begin
              if (round_due) begin
                tick_count <= '0;
                peer       <= '0;
                if (n_active != 5'd0) begin
                  state <= ST_ROUND;
                end
              end else begin
                tick_count <= tick_next;
              end
            end else if (pong_ok) begin
              peer  <= msg_client;
              state <= ST_PONG;
            end
          end
        end
        ST_ROUND: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {4'd0, peer};
            m_tuser  <= {1'b0, round_down, 1'b1};
            m_tlast  <= round_last;
            if (round_last) begin
              state <= ST_IDLE;
            end else begin
              peer <= peer + 4'd1;
            end
          end
        end
        ST_PONG: begin
          if (rd_level < LVL_WAIT) begin
            // back from a missed or away level
            if (out_free) begin
              m_tvalid <= 1'b1;
              m_tdata  <= {4'd0, peer};
              m_tuser  <= 3'b100;
              m_tlast  <= 1'b1;
              state    <= ST_IDLE;
            end
          end else begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/hblm_level_ram.sv @@
// liveness level store: registered-read ram with per-entry written bits
module hblm_level_ram #(
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output hblm_pkg::level_t   rd_level,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  hblm_pkg::level_t   wr_level
);
  import hblm_pkg::*;

  level_t           mem [DEPTH];
  level_t           mem_q;
  logic [DEPTH-1:0] written;
  logic             written_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_level;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // an entry never written reads as away
  always_ff @(posedge clk) begin
    if (rst) begin
      written   <= '0;
      written_q <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        written_q <= written[rd_addr];
      end
    end
  end

  assign rd_level = written_q ? mem_q : LVL_AWAY;

endmodule

@@ verif/heartbeat_liveness_monitor_tb.sv @@
// testbench for the heartbeat liveness monitor: stream and apb stimulus, scoreboard checked
`timescale 1ns / 100ps

module heartbeat_liveness_monitor_tb;
  import hblm_pkg::*;

  localparam int N_CLIENTS     = 16;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 20;
  localparam int PHASE_ITEMS   = 26;

  typedef struct packed {
    logic [3:0] peer;
    logic       ping;
    logic       down;
    logic       up;
    logic       last;
  } peer_event_t;

  // tracks interval count and client levels, holds the peer events still owed
  class liveness_scoreboard;
    logic [15:0] interval;
    logic [4:0]  client_reg;
    logic [15:0] ticks;
    level_t      level [N_CLIENTS];
    peer_event_t expected_q [$];
    int          errors;

    function new();
      interval   = INTERVAL_RESET;
      client_reg = COUNT_RESET;
      ticks      = '0;
      errors     = 0;
      foreach (level[i]) level[i] = LVL_AWAY;
    endfunction

    function int active();
      int n;
      n = client_reg;
      if (n > N_CLIENTS) n = N_CLIENTS;
      if (n > PEER_LIMIT) n = PEER_LIMIT;
      return n;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_config(reg_idx_t r, logic [31:0] value);
      case (r)
        REG_PING_INTERVAL: interval = value[15:0];
        REG_CLIENT_COUNT:  client_reg = value[4:0];
        default: ;
      endcase
    endfunction

    function void note_request(opcode_t op, logic [3:0] idx, logic [7:0] pay);
      int n;
      peer_event_t ev;
      n = active();
      if (op == OP_TICK) begin
        ticks = ticks + 16'd1;
        if (ticks >= interval) begin
          ticks = '0;
          for (int i = 0; i < n; i++) begin
            ev.peer = 4'(i);
            ev.ping = 1'b1;
            ev.down = 1'b0;
            ev.up   = 1'b0;
            ev.last = (i == n - 1);
            if (level[i] == LVL_MISS4) begin
              level[i] = LVL_AWAY;
              ev.down  = 1'b1;
            end else if (level[i] > LVL_MISS4) begin
              level[i] = level_t'(level[i] - 3'sd1);
            end
            expected_q.push_back(ev);
          end
        end
      end else if (int'(idx) < n && pay == PONG_BYTE) begin
        // only a missed or away level reports the link coming back
        if (level[idx] < LVL_WAIT) begin
          ev.peer = idx;
          ev.ping = 1'b0;
          ev.down = 1'b0;
          ev.up   = 1'b1;
          ev.last = 1'b1;
          expected_q.push_back(ev);
        end
        level[idx] = LVL_ALIVE;
      end
    endfunction

    function void check_result(logic [3:0] peer, logic [2:0] flags, logic last);
      peer_event_t ev;
      if (expected_q.size() == 0) begin
        $error("result for peer %0d with nothing pending", peer);
        errors++;
        return;
      end
      ev = expected_q.pop_front();
      if (peer !== ev.peer) begin
        $error("peer_index: expected %0d, got %0d", ev.peer, peer);
        errors++;
      end
      if (flags[0] !== ev.ping) begin
        $error("send_ping: expected %0d, got %0d", ev.ping, flags[0]);
        errors++;
      end
      if (flags[1] !== ev.down) begin
        $error("link_down: expected %0d, got %0d", ev.down, flags[1]);
        errors++;
      end
      if (flags[2] !== ev.up) begin
        $error("link_up: expected %0d, got %0d", ev.up, flags[2]);
        errors++;
      end
      if (last !== ev.last) begin
        $error("last: expected %0d, got %0d", ev.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;  // [3:0] client_index, [11:4] payload_byte, [15:12] zero
  logic [0:0]  s_tuser  = '0;  // [0] opcode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // [3:0] peer_index, [7:4] zero
  logic [2:0]  m_tuser;        // [0] send_ping, [1] link_down, [2] link_up
  logic        m_tlast;

  liveness_scoreboard sb;
  bit calm = 1'b0;
  int cycles = 0;

  heartbeat_liveness_monitor #(
    .MAX_CLIENTS(N_CLIENTS)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(negedge clk) begin
    m_tready <= calm || ($urandom_range(0, 99) >= 28);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata[3:0], m_tuser, m_tlast);
  end

  // valid stays high after a request is taken until the next call decides
  task automatic send_req(opcode_t op, logic [3:0] idx, logic [7:0] pay);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 28) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'h0, pay, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(op, idx, pay);
  endtask

  // drop valid, wait for every owed event, then let a round or pong wind down
  task automatic settle();
    @(negedge clk) s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(reg_idx_t r, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= value;
    @(negedge clk) penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.note_config(r, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int         useful;
    int         n;
    opcode_t    op;
    logic [3:0] idx;
    logic [7:0] pay;

    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // defaults: everybody away, long interval
    send_req(OP_MSG, 4'd0, PONG_BYTE);
    send_req(OP_MSG, 4'd15, PONG_BYTE);
    send_req(OP_MSG, 4'd3, 8'h00);
    send_req(OP_MSG, 4'd3, 8'hFF);
    send_req(OP_MSG, 4'd0, PONG_BYTE);
    send_req(OP_TICK, 4'hF, 8'hFF);
    settle();

    // zero interval: every tick is a round; walk client 0 down to away
    apb_write(REG_PING_INTERVAL, 32'd0);
    apb_write(REG_CLIENT_COUNT, 32'd16);
    send_req(OP_TICK, 4'd0, 8'd0);
    send_req(OP_MSG, 4'd0, PONG_BYTE);
    repeat (6) send_req(OP_TICK, 4'd0, 8'd0);
    send_req(OP_MSG, 4'd0, PONG_BYTE);
    send_req(OP_MSG, 4'd15, PONG_BYTE);
    settle();

    // no clients: round gives nothing, pongs ignored
    apb_write(REG_CLIENT_COUNT, 32'd0);
    send_req(OP_TICK, 4'd0, 8'd0);
    send_req(OP_MSG, 4'd0, PONG_BYTE);
    settle();

    // oversized client count saturates
    apb_write(REG_CLIENT_COUNT, 32'd31);
    apb_write(REG_PING_INTERVAL, 32'd1);
    send_req(OP_TICK, 4'd0, 8'd0);
    settle();

    // longest interval, then lowered below the running count
    apb_write(REG_PING_INTERVAL, 32'd65535);
    apb_write(REG_CLIENT_COUNT, 32'd1);
    repeat (3) send_req(OP_TICK, 4'd0, 8'd0);
    send_req(OP_MSG, 4'd1, PONG_BYTE);
    send_req(OP_MSG, 4'd0, PONG_BYTE);
    settle();
    apb_write(REG_PING_INTERVAL, 32'd2);
    send_req(OP_TICK, 4'd0, 8'd0);
    settle();

    for (int p = 0; p < 6; p++) begin
      calm = (p == 3);
      apb_write(REG_PING_INTERVAL, $urandom_range(0, 4));
      apb_write(REG_CLIENT_COUNT, (p == 1) ? 32'd31 : 32'($urandom_range(1, 31)));
      useful = 0;
      while (useful < PHASE_ITEMS) begin
        n = sb.active();
        if ($urandom_range(0, 99) < 45) begin
          op  = OP_TICK;
          idx = 4'($urandom);
          pay = 8'($urandom);
        end else begin
          op  = OP_MSG;
          idx = (n > 0 && $urandom_range(0, 99) < 75) ? 4'($urandom_range(0, n - 1))
                                                      : 4'($urandom_range(0, 15));
          pay = ($urandom_range(0, 99) < 70) ? PONG_BYTE : 8'($urandom_range(0, 255));
        end
        if (op == OP_TICK || (int'(idx) < n && pay == PONG_BYTE)) useful++;
        send_req(op, idx, pay);
      end
      settle();
    end
    calm = 1'b0;

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
